/* sv/semiflexible_bond_force_defines.svh */
// ----------------------------------------------------------------------------
// Semiflexible bond force - assertion macros
// Shorthand for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef SEMIFLEXIBLE_BOND_FORCE_DEFINES_SVH
`define SEMIFLEXIBLE_BOND_FORCE_DEFINES_SVH

// same-cycle implication, off while reset is held
`define SBF_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also checked through reset
`define SBF_AST_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/sbf_pkg.sv */
// ----------------------------------------------------------------------------
// Semiflexible bond force - package
// Widths, constants, pipeline stage positions, shared types and helpers.
// ----------------------------------------------------------------------------
package sbf_pkg;

  localparam int NUM_TYPES  = 2;
  localparam int CFG_TYPES  = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int DIST_W     = 40;
  localparam int OUT_W      = 48;
  localparam int TERM_W     = 51;
  localparam int QUOT_W     = 64;

  localparam logic [31:0] PI_Q30     = 32'd3373259426;
  localparam logic [63:0] PI_SQ_Q60  = {32'd0, PI_Q30} * {32'd0, PI_Q30};
  localparam logic [63:0] WARN_NUM   = 64'd9801;
  localparam logic [63:0] WARN_DEN   = 64'd10000;
  localparam logic [63:0] TERM_CAP   = 64'd1 << 50;
  localparam logic [31:0] COEF_RESET = 32'h0001_0000;

  localparam logic signed [52:0] OUT_MAX_W = 53'sd140737488355327;
  localparam logic signed [52:0] OUT_MIN_W = -53'sd140737488355328;

  // pipeline positions: a unit fed from ctx_r[P] delivers alongside ctx_r[P + LAT]
  localparam int MUL_LAT   = 2;
  localparam int DIV_LAT   = QUOT_W;
  localparam int P_MA      = 0;
  localparam int P_MA_OUT  = P_MA + MUL_LAT;
  localparam int P_MB      = P_MA_OUT + 1;
  localparam int P_MB_OUT  = P_MB + MUL_LAT;
  localparam int P_D1      = P_MB_OUT;
  localparam int P_D1_OUT  = P_D1 + DIV_LAT;
  localparam int P_MC      = P_D1_OUT;
  localparam int P_MC_OUT  = P_MC + MUL_LAT;
  localparam int P_D2      = P_MC_OUT;
  localparam int P_D2_OUT  = P_D2 + DIV_LAT;
  localparam int P_MD      = P_D2_OUT;
  localparam int P_MD_OUT  = P_MD + MUL_LAT;
  localparam int P_D3      = P_MD_OUT;
  localparam int P_D3_OUT  = P_D3 + DIV_LAT;
  localparam int CTX_DEPTH = P_D3_OUT + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP1 = 3'd0,
    CFG_PLEN1 = 3'd1,
    CFG_MLEN1 = 3'd2,
    CFG_TEMP2 = 3'd3,
    CFG_PLEN2 = 3'd4,
    CFG_MLEN2 = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_WARN = 2'd1,
    ST_ERR  = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] plen;
    logic [31:0] mlen;
  } coef_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] lo;
    logic [63:0] q;
    logic [63:0] c;
    logic        sat;
  } div_stage_t;

  typedef struct packed {
    logic [31:0]       t;
    logic [31:0]       p;
    logic [31:0]       l;
    logic [55:0]       a;
    logic [63:0]       l2;
    logic [63:0]       x;
    logic [63:0]       cz;
    logic [63:0]       d;
    logic              err;
    logic              warn;
    logic [TERM_W-1:0] f1c;
    logic [TERM_W-1:0] e1c;
    logic [TERM_W-1:0] e2c;
    logic              z_sat;
    logic              dq_sat;
    logic              y_sat;
    logic              v_sat;
  } ctx_t;

  // round half up of a quotient that carries one extra fraction bit
  function automatic logic [63:0] round_half(input logic [63:0] q);
    return {1'b0, q[63:1]} + {63'd0, q[0]};
  endfunction

  function automatic logic [TERM_W-1:0] clamp_term(input logic [63:0] v, input logic sat);
    if (sat || v > TERM_CAP) return TERM_CAP[TERM_W-1:0];
    return v[TERM_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] sat_out(input logic signed [52:0] v);
    if (v > OUT_MAX_W) return OUT_MAX_W[OUT_W-1:0];
    if (v < OUT_MIN_W) return OUT_MIN_W[OUT_W-1:0];
    return v[OUT_W-1:0];
  endfunction

endpackage

/* sv/sbf_mul64.sv */
// ----------------------------------------------------------------------------
// Semiflexible bond force - 64x64 multiplier
// Four 32x32 partial products, registered, then summed into a registered
// 128-bit product. New operands every cycle.
// ----------------------------------------------------------------------------
module sbf_mul64 (
  input  logic         clk,
  input  logic [63:0]  a,
  input  logic [63:0]  b,
  output logic [127:0] prod
);

  logic [63:0]  pll_r, plh_r, phl_r, phh_r;
  logic [127:0] prod_r;

  always_ff @(posedge clk) begin
    pll_r  <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
    plh_r  <= {32'd0, a[31:0]} * {32'd0, b[63:32]};
    phl_r  <= {32'd0, a[63:32]} * {32'd0, b[31:0]};
    phh_r  <= {32'd0, a[63:32]} * {32'd0, b[63:32]};
    prod_r <= {phh_r, 64'd0} + {32'd0, plh_r, 32'd0} + {32'd0, phl_r, 32'd0}
              + {64'd0, pll_r};
  end

  assign prod = prod_r;

endmodule

/* sv/sbf_div_cell.sv */
// ----------------------------------------------------------------------------
// Semiflexible bond force - divider cell
// One restoring step: shifts in the next dividend bit, subtracts the divisor
// when it fits and appends one quotient bit. Output registered.
// ----------------------------------------------------------------------------
module sbf_div_cell (
  input  logic                clk,
  input  sbf_pkg::div_stage_t d_in,
  output sbf_pkg::div_stage_t d_out
);
  import sbf_pkg::*;

  logic [64:0] rem_sh;
  logic        ge;
  div_stage_t  stg_nxt, stg_r;

  always_comb begin
    rem_sh      = {d_in.rem, d_in.lo[63]};
    ge          = rem_sh >= {1'b0, d_in.c};
    stg_nxt     = d_in;
    // remainder stays below the divisor, so 64 bits hold it
    stg_nxt.rem = ge ? 64'(rem_sh - {1'b0, d_in.c}) : rem_sh[63:0];
    stg_nxt.lo  = {d_in.lo[62:0], 1'b0};
    stg_nxt.q   = {d_in.q[62:0], ge};
  end

  always_ff @(posedge clk) begin
    stg_r <= stg_nxt;
  end

  assign d_out = stg_r;

endmodule

/* sv/sbf_div.sv */
// ----------------------------------------------------------------------------
// Semiflexible bond force - pipelined divider
// Chain of 64 divider cells: quotient of a 129-bit dividend by a 64-bit
// divisor, rounded half up on its last bit, flagged when it reaches 2^64.
// ----------------------------------------------------------------------------
module sbf_div (
  input  logic        clk,
  input  logic [64:0] num_hi,
  input  logic [63:0] num_lo,
  input  logic [63:0] den,
  input  logic        sat_in,
  output logic [63:0] quot,
  output logic        sat_out
);
  import sbf_pkg::*;

  div_stage_t stg_head;
  div_stage_t stg_chain [DIV_LAT];

  always_comb begin
    // quotient overflows iff the upper part alone already covers the divisor
    stg_head.sat = sat_in || (num_hi >= {1'b0, den});
    stg_head.rem = stg_head.sat ? 64'd0 : num_hi[63:0];
    stg_head.lo  = num_lo;
    stg_head.q   = 64'd0;
    stg_head.c   = den;
  end

  for (genvar i = 0; i < DIV_LAT; i++) begin : g_cell
    if (i == 0) begin : g_first
      sbf_div_cell u_cell (.clk(clk), .d_in(stg_head), .d_out(stg_chain[i]));
    end else begin : g_next
      sbf_div_cell u_cell (.clk(clk), .d_in(stg_chain[i-1]), .d_out(stg_chain[i]));
    end
  end

  assign quot    = round_half(stg_chain[DIV_LAT-1].q);
  assign sat_out = stg_chain[DIV_LAT-1].sat;

endmodule

/* sv/semiflexible_bond_force.sv */
// ----------------------------------------------------------------------------
// Semiflexible bond force - top level
// Force over distance and energy of a semiflexible rod bond, Q16.16, from the
// squared length, without a square root.
// ----------------------------------------------------------------------------
//  channel  handshake             payload
//  in       start & !busy         in_bond_type, in_dist_sq
//  out      out_valid (1 cycle)   out_force_over_r, out_bond_energy, out_status
//  cfg      cfg_valid & cfg_ready cfg_index, cfg_data
//
//  One bond per cycle; busy and cfg_ready are constant, so every start is taken.
//  Between the edge that takes the start beat and out_valid lie three
//  64-cell divider chains, four multiplier stages, one alignment stage and
//  the output register.
//  Synchronous reset flushes all valid bits and loads 1.0 into every coefficient.
//  No stall path: the output is a one-cycle strobe.
// ----------------------------------------------------------------------------
module semiflexible_bond_force (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_bond_type,
  input  logic [sbf_pkg::DIST_W-1:0]     in_dist_sq,
  output logic                           out_valid,
  output logic signed [sbf_pkg::OUT_W-1:0] out_force_over_r,
  output logic signed [sbf_pkg::OUT_W-1:0] out_bond_energy,
  output logic [1:0]                     out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import sbf_pkg::*;

  coef_t                coef_r [CFG_TYPES];
  coef_t                coef_sel;
  ctx_t                 ctx_r   [CTX_DEPTH];
  ctx_t                 ctx_nxt [CTX_DEPTH];
  logic [CTX_DEPTH-1:0] vld_r;
  logic                 accept;

  logic [127:0] prod_l2, prod_x, prod_cz, prod_f1, prod_wa, prod_wl;
  logic [127:0] prod_y, prod_v, prod_f2, prod_e2, prod_e1;
  logic [63:0]  f1_q, z_q, dq_q, y_q, v_q, f2_q;
  logic         f1_sat, z_sat, dq_sat, y_sat, v_sat, f2_sat;

  logic [63:0]        n_e2, n_e1;
  logic [TERM_W-1:0]  f2c;
  logic signed [52:0] force_w, energy_w;

  logic                    out_valid_r;
  logic [OUT_W-1:0]        force_r, energy_r;
  status_t                 status_r;
  logic [OUT_W-1:0]        force_nxt, energy_nxt;
  status_t                 status_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // coefficient registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CFG_TYPES; i++) begin
        coef_r[i] <= '{temp: COEF_RESET, plen: COEF_RESET, mlen: COEF_RESET};
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TEMP1: coef_r[0].temp <= cfg_data;
        CFG_PLEN1: coef_r[0].plen <= cfg_data;
        CFG_MLEN1: coef_r[0].mlen <= cfg_data;
        CFG_TEMP2: coef_r[1].temp <= cfg_data;
        CFG_PLEN2: coef_r[1].plen <= cfg_data;
        CFG_MLEN2: coef_r[1].mlen <= cfg_data;
        default: ;
      endcase
    end
  end

  // a type beyond the configured count falls back to the last one
  assign coef_sel = (int'(in_bond_type) >= NUM_TYPES) ? coef_r[NUM_TYPES-1]
                                                      : coef_r[in_bond_type];

  // multipliers and dividers along the context line
  sbf_mul64 u_mul_l2 (.clk(clk), .a({32'd0, ctx_r[P_MA].l}), .b({32'd0, ctx_r[P_MA].l}),
                      .prod(prod_l2));
  sbf_mul64 u_mul_x  (.clk(clk), .a({32'd0, ctx_r[P_MA].t}), .b({32'd0, ctx_r[P_MA].p}),
                      .prod(prod_x));
  sbf_mul64 u_mul_cz (.clk(clk), .a({32'd0, ctx_r[P_MA].p}), .b({32'd0, PI_Q30}),
                      .prod(prod_cz));

  sbf_mul64 u_mul_f1 (.clk(clk), .a(ctx_r[P_MB].x), .b(PI_SQ_Q60), .prod(prod_f1));
  sbf_mul64 u_mul_wa (.clk(clk), .a({8'd0, ctx_r[P_MB].a}), .b(WARN_DEN), .prod(prod_wa));
  sbf_mul64 u_mul_wl (.clk(clk), .a(ctx_r[P_MB].l2), .b(WARN_NUM), .prod(prod_wl));

  sbf_div u_div_f1 (.clk(clk), .num_hi({44'd0, prod_f1[127:107]}), .num_lo(prod_f1[106:43]),
                    .den(ctx_r[P_D1].l2), .sat_in(1'b0), .quot(f1_q), .sat_out(f1_sat));
  sbf_div u_div_z  (.clk(clk), .num_hi({34'd0, ctx_r[P_D1].t[31:1]}),
                    .num_lo({ctx_r[P_D1].t[0], 63'd0}), .den(ctx_r[P_D1].cz),
                    .sat_in(1'b0), .quot(z_q), .sat_out(z_sat));
  sbf_div u_div_dq (.clk(clk), .num_hi({1'b0, ctx_r[P_D1].d}), .num_lo(64'd0),
                    .den(ctx_r[P_D1].l2), .sat_in(1'b0), .quot(dq_q), .sat_out(dq_sat));

  sbf_mul64 u_mul_y (.clk(clk), .a(z_q), .b(ctx_r[P_MC].l2), .prod(prod_y));
  sbf_mul64 u_mul_v (.clk(clk), .a(ctx_r[P_MC].x), .b(dq_q), .prod(prod_v));

  sbf_div u_div_y (.clk(clk), .num_hi(prod_y[127:63]), .num_lo({prod_y[62:0], 1'b0}),
                   .den(ctx_r[P_D2].d), .sat_in(ctx_r[P_D2].z_sat), .quot(y_q),
                   .sat_out(y_sat));
  sbf_div u_div_v (.clk(clk), .num_hi({47'd0, prod_v[127:110]}), .num_lo(prod_v[109:46]),
                   .den({32'd0, ctx_r[P_D2].l}), .sat_in(ctx_r[P_D2].dq_sat), .quot(v_q),
                   .sat_out(v_sat));

  sbf_mul64 u_mul_f2 (.clk(clk), .a(y_q), .b(ctx_r[P_MD].l2), .prod(prod_f2));
  sbf_mul64 u_mul_e2 (.clk(clk), .a({32'd0, ctx_r[P_MD].l}), .b(y_q), .prod(prod_e2));
  sbf_mul64 u_mul_e1 (.clk(clk), .a(v_q), .b(PI_SQ_Q60), .prod(prod_e1));

  sbf_div u_div_f2 (.clk(clk), .num_hi({14'd0, prod_f2[127:77]}), .num_lo(prod_f2[76:13]),
                    .den(ctx_r[P_D3].d), .sat_in(ctx_r[P_D3].y_sat), .quot(f2_q),
                    .sat_out(f2_sat));

  assign n_e2 = prod_e2[93:30];
  assign n_e1 = {12'd0, prod_e1[127:76]};

  always_comb begin
    ctx_nxt[0]    = '0;
    ctx_nxt[0].t  = coef_sel.temp;
    ctx_nxt[0].p  = (coef_sel.plen == 32'd0) ? 32'd1 : coef_sel.plen;
    ctx_nxt[0].l  = (coef_sel.mlen == 32'd0) ? 32'd1 : coef_sel.mlen;
    ctx_nxt[0].a  = {in_dist_sq, 16'd0};
    for (int i = 1; i < CTX_DEPTH; i++) begin
      ctx_nxt[i] = ctx_r[i-1];
    end

    ctx_nxt[P_MA_OUT+1].l2  = prod_l2[63:0];
    ctx_nxt[P_MA_OUT+1].x   = prod_x[63:0];
    ctx_nxt[P_MA_OUT+1].cz  = prod_cz[63:0];
    ctx_nxt[P_MA_OUT+1].err = {8'd0, ctx_r[P_MA_OUT].a} >= prod_l2[63:0];
    ctx_nxt[P_MA_OUT+1].d   = prod_l2[63:0] - {8'd0, ctx_r[P_MA_OUT].a};

    ctx_nxt[P_MB_OUT+1].warn = prod_wa >= prod_wl;

    ctx_nxt[P_D1_OUT+1].f1c    = clamp_term(f1_q, f1_sat);
    ctx_nxt[P_D1_OUT+1].z_sat  = z_sat;
    ctx_nxt[P_D1_OUT+1].dq_sat = dq_sat;

    ctx_nxt[P_D2_OUT+1].y_sat = y_sat;
    ctx_nxt[P_D2_OUT+1].v_sat = v_sat;

    // energy terms have a divisor of one: shift, round, overflow check
    ctx_nxt[P_MD_OUT+1].e2c = clamp_term(round_half(n_e2),
                                         ctx_r[P_MD_OUT].y_sat || (|prod_e2[127:94]));
    ctx_nxt[P_MD_OUT+1].e1c = clamp_term(round_half(n_e1), ctx_r[P_MD_OUT].v_sat);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CTX_DEPTH; i++) begin
      ctx_r[i] <= ctx_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[CTX_DEPTH-2:0], accept};
    end
  end

  // final combine
  always_comb begin
    f2c      = clamp_term(f2_q, f2_sat);
    force_w  = $signed({2'b00, ctx_r[P_D3_OUT].f1c}) - $signed({2'b00, f2c});
    energy_w = $signed({2'b00, ctx_r[P_D3_OUT].e1c}) + $signed({2'b00, ctx_r[P_D3_OUT].e2c});
    if (ctx_r[P_D3_OUT].err) begin
      force_nxt  = '0;
      energy_nxt = '0;
      status_nxt = ST_ERR;
    end else begin
      force_nxt  = sat_out(force_w);
      energy_nxt = sat_out(energy_w);
      status_nxt = ctx_r[P_D3_OUT].warn ? ST_WARN : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[CTX_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    force_r  <= force_nxt;
    energy_r <= energy_nxt;
    status_r <= status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_force_over_r = force_r;
  assign out_bond_energy  = energy_r;
  assign out_status       = status_r;

endmodule

/* sv/sbf_checker.sv */
// ----------------------------------------------------------------------------
// Semiflexible bond force - port checker
// Watches the result, start and coefficient ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "semiflexible_bond_force_defines.svh"

module sbf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_valid,
  input logic signed [sbf_pkg::OUT_W-1:0] out_force_over_r,
  input logic signed [sbf_pkg::OUT_W-1:0] out_bond_energy,
  input logic [1:0]                       out_status,
  input logic                             cfg_valid,
  input logic                             cfg_ready
);
  import sbf_pkg::*;

  // fully stretched bonds report nothing but the status
  `SBF_AST_IMP(a_err_zero, out_valid && out_status == ST_ERR, out_force_over_r == '0 && out_bond_energy == '0, "error beat with nonzero payload")

  // both energy terms are non-negative
  `SBF_AST_IMP(a_energy_nonneg, out_valid, !out_bond_energy[OUT_W-1], "negative bond energy")

  // one bond per cycle: a start is never held off
  `SBF_AST_IMP(a_start_taken, start, !busy, "start beat refused")

  `SBF_AST_IMP(a_cfg_taken, cfg_valid, cfg_ready, "coefficient write refused")

  `SBF_AST_RST(a_reset_flush, !rst_n, !out_valid, "result beat right after reset")

endmodule

bind semiflexible_bond_force sbf_checker u_sbf_checker (.*);

/* bench/semiflexible_bond_force_tb.sv */
// ----------------------------------------------------------------------------
// Semiflexible bond force - testbench
// Drives bond beats and coefficient writes, predicts force, energy and status
// in fixed point, and checks every result strobe in order against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module semiflexible_bond_force_tb;
  import sbf_pkg::*;

  localparam int  LATENCY   = 203;
  localparam int  LIMIT     = 600000;
  localparam int  N_RANDOM  = 450;

  typedef struct {
    logic [OUT_W-1:0] force_r;
    logic [OUT_W-1:0] energy;
    status_t          status;
  } bond_result_t;

  class bond_scoreboard;
    logic [31:0]  coef [6];
    bond_result_t pending [$];
    int           errors;
    int           checked;

    function new();
      for (int i = 0; i < 6; i++) coef[i] = COEF_RESET;
      errors  = 0;
      checked = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [31:0] val);
      coef[idx] = val;
    endfunction

    // round(a*b*2^k/c) by restoring division; saturates once the quotient hits 2^63
    function logic [63:0] scaled_div(logic [63:0] a, logic [63:0] b, logic [63:0] c,
                                     int k, inout bit sat);
      logic [127:0] prod;
      logic [64:0]  rem;
      logic [63:0]  q;
      int           pos;
      bit           qb;
      if (sat || c == 0) begin
        sat = 1;
        return '1;
      end
      prod = {64'd0, a} * {64'd0, b};
      rem  = '0;
      q    = '0;
      for (int i = 0; i < 129 + k; i++) begin
        pos = 127 - i;
        rem = {rem[63:0], (pos >= 0) ? prod[pos] : 1'b0};
        qb  = rem >= {1'b0, c};
        if (qb) rem = rem - {1'b0, c};
        if (q[63]) begin
          sat = 1;
          return '1;
        end
        q = {q[62:0], qb};
      end
      return (q >> 1) + q[0];
    endfunction

    function logic signed [63:0] cap_term(logic [63:0] v, bit sat);
      if (sat || v > TERM_CAP) return TERM_CAP;
      return v;
    endfunction

    function logic [OUT_W-1:0] sat48(logic signed [63:0] v);
      if (v > 64'sd140737488355327) return 48'h7FFF_FFFF_FFFF;
      if (v < -64'sd140737488355328) return 48'h8000_0000_0000;
      return v[OUT_W-1:0];
    endfunction

    function void note_bond(logic bt, logic [DIST_W-1:0] ds);
      logic [63:0]  t, p, l, l2, a, d, x, f1, z, y, f2, e2, dq, v, e1;
      logic [127:0] lhs, rhs;
      bit           s1, sy, sf2, se2, se1;
      bond_result_t r;
      t = coef[bt ? CFG_TEMP2 : CFG_TEMP1];
      p = coef[bt ? CFG_PLEN2 : CFG_PLEN1];
      l = coef[bt ? CFG_MLEN2 : CFG_MLEN1];
      if (p == 0) p = 1;
      if (l == 0) l = 1;
      l2 = l * l;
      a  = {24'd0, ds} << 16;
      if (a >= l2) begin
        r.force_r = '0;
        r.energy  = '0;
        r.status  = ST_ERR;
        pending.push_back(r);
        return;
      end
      d   = l2 - a;
      x   = t * p;
      lhs = {64'd0, a} * {64'd0, WARN_DEN};
      rhs = {64'd0, l2} * {64'd0, WARN_NUM};
      r.status = (lhs >= rhs) ? ST_WARN : ST_OK;
      s1 = 0; sy = 0; se1 = 0;
      f1  = scaled_div(PI_SQ_Q60, x, l2, -44, s1);
      z   = scaled_div(t, 64'd1, {32'd0, PI_Q30} * p, 62, sy);
      y   = scaled_div(z, l2, d, 0, sy);
      sf2 = sy;
      se2 = sy;
      f2  = scaled_div(y, l2, d, -14, sf2);
      e2  = scaled_div(l, y, 64'd1, -31, se2);
      dq  = scaled_div(d, 64'd1, l2, 63, se1);
      v   = scaled_div(x, dq, l, -47, se1);
      e1  = scaled_div(v, PI_SQ_Q60, 64'd1, -77, se1);
      r.force_r = sat48(cap_term(f1, s1) - cap_term(f2, sf2));
      r.energy  = sat48(cap_term(e1, se1) + cap_term(e2, se2));
      pending.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      errors++;
    endtask

    task check_result(logic [OUT_W-1:0] f, logic [OUT_W-1:0] e, logic [1:0] s);
      bond_result_t w;
      checked++;
      if (pending.size() == 0) begin
        report("unexpected result", {s, e[13:0], f}, 64'd0);
        return;
      end
      w = pending.pop_front();
      if (f !== w.force_r) report("force_over_r", f, w.force_r);
      if (e !== w.energy)  report("bond_energy", e, w.energy);
      if (s !== w.status)  report("status", s, w.status);
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic                  in_bond_type;
  logic [DIST_W-1:0]     in_dist_sq;
  logic                  out_valid;
  logic [OUT_W-1:0]      out_force_over_r;
  logic [OUT_W-1:0]      out_bond_energy;
  logic [1:0]            out_status;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bond_scoreboard sb = new();
  int  cycles;
  int  idle_pct;
  int  n_bonds;

  semiflexible_bond_force u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_bond_type     (in_bond_type),
    .in_dist_sq       (in_dist_sq),
    .out_valid        (out_valid),
    .out_force_over_r (out_force_over_r),
    .out_bond_energy  (out_bond_energy),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // accepted bond beats and result strobes, sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      sb.note_bond(in_bond_type, in_dist_sq);
      n_bonds++;
    end
    if (rst_n && out_valid) sb.check_result(out_force_over_r, out_bond_energy, out_status);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TEST FAILED");
      $finish;
    end
  end

  // called just after a falling edge; returns just after a later one
  task send_bond(logic bt, logic [DIST_W-1:0] ds);
    in_bond_type = bt;
    in_dist_sq   = ds;
    start        = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    // sender sits idle in about idle_pct cycles of a hundred
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
  endtask

  task write_reg(cfg_idx_t idx, logic [31:0] val);
    start     = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task drain();
    start = 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task set_type(logic bt, logic [31:0] t, logic [31:0] p, logic [31:0] l);
    write_reg(bt ? CFG_TEMP2 : CFG_TEMP1, t);
    write_reg(bt ? CFG_PLEN2 : CFG_PLEN1, p);
    write_reg(bt ? CFG_MLEN2 : CFG_MLEN1, l);
  endtask

  // squared length at which extension reaches one; below it the block computes
  function logic [63:0] full_len_sq(logic bt);
    logic [63:0] l;
    l = sb.coef[bt ? CFG_MLEN2 : CFG_MLEN1];
    if (l == 0) l = 1;
    return (l * l + 64'hFFFF) >> 16;
  endfunction

  function logic [DIST_W-1:0] pick_dist(logic bt);
    logic [63:0]  thr;
    logic [127:0] w;
    thr = full_len_sq(bt);
    case ($urandom_range(9))
      0:       w = {64'd0, $urandom, $urandom};
      1:       w = {64'd0, thr} + 128'($urandom_range(0, 2)) - 128'd1;
      2: begin
        // near the warning edge
        w = ({64'd0, thr} * 128'd9801) / 128'd10000 + 128'($urandom_range(0, 4)) - 128'd2;
      end
      default: begin
        w = ({64'd0, thr} * 128'($urandom_range(0, 1030))) / 128'd1000;
      end
    endcase
    return w[DIST_W-1:0];
  endfunction

  task random_bonds(int n);
    logic bt;
    repeat (n) begin
      bt = 1'($urandom_range(1));
      send_bond(bt, pick_dist(bt));
    end
  endtask

  task directed_bonds();
    logic        bt;
    logic [63:0] thr, wthr;
    for (int b = 0; b < 2; b++) begin
      bt   = b[0];
      thr  = full_len_sq(bt);
      wthr = (thr * 64'd9801) / 64'd10000;
      send_bond(bt, '0);
      send_bond(bt, '1);
      send_bond(bt, thr[DIST_W-1:0]);
      send_bond(bt, DIST_W'(thr - 64'd1));
      send_bond(bt, wthr[DIST_W-1:0]);
      send_bond(bt, DIST_W'(wthr + 64'd1));
      send_bond(bt, 40'h55_5555_5555);
      send_bond(bt, 40'hAA_AAAA_AAAA);
    end
  endtask

  initial begin
    cycles       = 0;
    n_bonds      = 0;
    idle_pct     = 13;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_bond_type = 1'b0;
    in_dist_sq   = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_TEMP1;
    cfg_data     = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset coefficients, then a spread of settings including the extremes
    directed_bonds();
    drain();
    set_type(1'b0, 32'h0001_8000, 32'h0004_0000, 32'h0002_0000);
    set_type(1'b1, 32'h0000_4000, 32'h0000_8000, 32'h0010_0000);
    directed_bonds();
    random_bonds(N_RANDOM / 3);
    drain();

    idle_pct = 74;
    set_type(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    set_type(1'b1, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    directed_bonds();
    random_bonds(N_RANDOM / 6);
    drain();
    set_type(1'b0, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    set_type(1'b1, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0100);
    random_bonds(N_RANDOM / 6);
    drain();

    idle_pct = 0;
    set_type(1'b0, $urandom, $urandom_range(1, 32'h0020_0000),
             $urandom_range(32'h8000, 32'h0040_0000));
    set_type(1'b1, $urandom_range(0, 32'h0004_0000), $urandom,
             $urandom_range(32'h100, 32'h0100_0000));
    random_bonds(N_RANDOM / 3);
    drain();

    repeat (LATENCY + 20) @(negedge clk);
    $display("covered %0d bond beats, %0d results checked, over several coefficient sets",
             n_bonds, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/sbf_pkg.sv
sv/sbf_mul64.sv
sv/sbf_div_cell.sv
sv/sbf_div.sv
sv/semiflexible_bond_force.sv
sv/sbf_checker.sv
bench/semiflexible_bond_force_tb.sv
